// ===== src/csg_pkg.sv =====
`timescale 1ns / 1ps
package csg_pkg;

  localparam int unsigned FRACTION_BITS    = 16;
  localparam int unsigned ANGLE_ITERATIONS = 24;
  localparam int unsigned ROOT_STEPS       = 32;
  localparam int unsigned DIV_STEPS        = 32;
  localparam int unsigned ROOT_LANES       = 3;

  localparam int unsigned PW  = FRACTION_BITS + 2;
  localparam int unsigned ZW  = FRACTION_BITS + 4;
  localparam int unsigned CW  = 48;
  localparam int unsigned RW  = 80;
  localparam int unsigned AIW = $clog2(ANGLE_ITERATIONS);
  localparam int unsigned RSW = $clog2(ROOT_STEPS);
  localparam int unsigned DSW = $clog2(DIV_STEPS);

  localparam logic [47:0] MAX48  = '1;
  localparam logic [39:0] PI_Q32 = 40'd13493037704;

  localparam logic [31:0] ATAN_HEAD [11] = '{
    32'd3373259426, 32'd1991351318, 32'd1052175346, 32'd534100635,
    32'd268086748, 32'd134174063, 32'd67103403, 32'd33553749,
    32'd16777131, 32'd8388597, 32'd4194303
  };

  function automatic logic [39:0] to_angle_q(input logic [39:0] v);
    return (v + (40'd1 << (31 - FRACTION_BITS))) >> (32 - FRACTION_BITS);
  endfunction

  function automatic logic [39:0] atan_q(input logic [7:0] i);
    logic [39:0] v;
    if (i <= 8'd10) begin
      v = 40'(ATAN_HEAD[i[3:0]]);
    end else if (i <= 8'd32) begin
      v = 40'd1 << (8'd32 - i);
    end else begin
      v = '0;
    end
    return to_angle_q(v);
  endfunction

  localparam logic [PW-1:0] PI_ANG = PW'(to_angle_q(PI_Q32));
  localparam logic [PW-1:0] ZMAX   = PI_ANG >> 1;

  typedef enum logic [2:0] {
    REG_SHAPE  = 3'd0,
    REG_DIAM   = 3'd1,
    REG_BASE   = 3'd2,
    REG_LSLOPE = 3'd3,
    REG_RSLOPE = 3'd4
  } csg_reg_e;

  typedef enum logic {
    SHAPE_PIPE = 1'b0,
    SHAPE_TRAP = 1'b1
  } csg_shape_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_CLAMP = 2'd1,
    ST_SAT   = 2'd2
  } csg_status_e;

  typedef struct packed {
    csg_shape_e    shape;
    logic          clamped;
    logic          neg;
    logic [31:0]   depth;
    logic [31:0]   diam;
    logic [31:0]   base;
    logic [23:0]   lslope;
    logic [23:0]   rslope;
    logic [24:0]   ssum;
    logic [31:0]   ax;
    logic [56:0]   dss;
    logic [63:0]   bd;
    logic [63:0]   dsq;
    logic [31:0]   s;
    logic [32:0]   k;
    logic [63:0]   prod_lo;
    logic [56:0]   prod_hi;
    logic [64:0]   dk;
    logic [PW-1:0] phi;
    logic [63:0]   tarea;
    logic [47:0]   tperim;
    logic [63:0]   pp_lo;
    logic [63:0]   pp_hi;
    logic [63:0]   axs;
    logic [47:0]   cperim;
    logic [63:0]   area;
    logic [47:0]   perim;
    logic [47:0]   width;
    logic          pzero;
    logic          hrsat;
  } csg_word_t;

  typedef struct packed {
    csg_word_t                  w;
    logic [ROOT_LANES-1:0][63:0] rad;
    logic [ROOT_LANES-1:0][63:0] root;
  } csg_root_t;

  typedef struct packed {
    csg_word_t             w;
    logic signed [CW-1:0]  cx;
    logic signed [CW-1:0]  cy;
    logic signed [ZW-1:0]  z;
  } csg_rot_t;

  typedef struct packed {
    csg_word_t   w;
    logic [RW-1:0] rem;
    logic [31:0] quo;
  } csg_div_t;

  typedef struct packed {
    logic [47:0] flow_area;
    logic [47:0] wetted_perimeter;
    logic [47:0] surface_width;
    logic [31:0] hydraulic_radius;
    logic [1:0]  status;
  } csg_out_t;

endpackage

// ===== src/csg_if.sv =====
`timescale 1ns / 1ps
interface csg_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] flow_depth;

  modport source (output valid, output flow_depth, input ready);
  modport sink (input valid, input flow_depth, output ready);
endinterface

interface csg_out_if;
  logic        valid;
  logic        ready;
  logic [47:0] flow_area;
  logic [47:0] wetted_perimeter;
  logic [47:0] surface_width;
  logic [31:0] hydraulic_radius;
  logic [1:0]  status;

  modport source (output valid, output flow_area, output wetted_perimeter,
                  output surface_width, output hydraulic_radius, output status,
                  input ready);
  modport sink (input valid, input flow_area, input wetted_perimeter,
                input surface_width, input hydraulic_radius, input status,
                output ready);
endinterface

// ===== src/csg_root_cell.sv =====
`timescale 1ns / 1ps
module csg_root_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic [csg_pkg::RSW-1:0] step_i,
  input  logic                valid_i,
  input  csg_pkg::csg_root_t  d_i,
  output logic                valid_o,
  output csg_pkg::csg_root_t  q_o
);
  import csg_pkg::*;

  logic [6:0]  sh;
  logic [63:0] bit_w;
  logic [63:0] trial;
  csg_root_t   nxt;

  always_comb begin
    sh    = 7'(2 * (ROOT_STEPS - 1)) - {1'b0, step_i, 1'b0};
    bit_w = 64'd1 << sh;
    nxt   = d_i;
    trial = '0;
    for (int l = 0; l < ROOT_LANES; l++) begin
      trial = d_i.root[l] + bit_w;
      if (d_i.rad[l] >= trial) begin
        nxt.rad[l]  = d_i.rad[l] - trial;
        nxt.root[l] = (d_i.root[l] >> 1) + bit_w;
      end else begin
        nxt.root[l] = d_i.root[l] >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_o <= nxt;
    end
  end
endmodule

// ===== src/csg_rot_cell.sv =====
`timescale 1ns / 1ps
module csg_rot_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic [csg_pkg::AIW-1:0] step_i,
  input  logic                valid_i,
  input  csg_pkg::csg_rot_t   d_i,
  output logic                valid_o,
  output csg_pkg::csg_rot_t   q_o
);
  import csg_pkg::*;

  logic signed [CW-1:0] cx, cy, dx, dy;
  logic signed [ZW-1:0] z, a;
  csg_rot_t             nxt;

  always_comb begin
    cx  = d_i.cx;
    cy  = d_i.cy;
    z   = d_i.z;
    dx  = cy >>> step_i;
    dy  = cx >>> step_i;
    a   = signed'(ZW'(atan_q(8'(step_i))));
    nxt = d_i;
    if (!cy[CW-1]) begin
      nxt.cx = cx + dx;
      nxt.cy = cy - dy;
      nxt.z  = z + a;
    end else begin
      nxt.cx = cx - dx;
      nxt.cy = cy + dy;
      nxt.z  = z - a;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_o <= nxt;
    end
  end
endmodule

// ===== src/csg_div_cell.sv =====
`timescale 1ns / 1ps
module csg_div_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic [csg_pkg::DSW-1:0] step_i,
  input  logic                valid_i,
  input  csg_pkg::csg_div_t   d_i,
  output logic                valid_o,
  output csg_pkg::csg_div_t   q_o
);
  import csg_pkg::*;

  logic [DSW-1:0] pos;
  logic [RW-1:0]  trial;
  csg_div_t       nxt;

  always_comb begin
    pos   = DSW'(DIV_STEPS - 1) - step_i;
    trial = RW'(d_i.w.perim) << pos;
    nxt   = d_i;
    if (d_i.rem >= trial) begin
      nxt.rem = d_i.rem - trial;
      nxt.quo = d_i.quo | (32'd1 << pos);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_o <= nxt;
    end
  end
endmodule

// ===== src/channel_section_geometry.sv =====
`timescale 1ns / 1ps
// Pipeline: two 32-cell root and divide chains, the angle chain of ANGLE_ITERATIONS
//   cells, and the arithmetic stages s0 to s6 in between, then the output register.
// Throughput: one beat per cycle unless stalled; every cell advances together.
// A skid register behind the output register holds one result under back-pressure.
// Reset: asynchronous, clears all valid bits; registers return to pipe of diameter 1.0.
module channel_section_geometry (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  csg_in_if.sink      in_ch,
  csg_out_if.source   out_ch
);
  import csg_pkg::*;

  csg_shape_e  shape_q;
  logic [31:0] diam_q, base_q;
  logic [23:0] lslope_q, rslope_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_q  <= SHAPE_PIPE;
      diam_q   <= 32'd65536;
      base_q   <= '0;
      lslope_q <= '0;
      rslope_q <= '0;
    end else if (cfg_we_i) begin
      unique case (csg_reg_e'(cfg_idx_i))
        REG_SHAPE:  shape_q  <= csg_shape_e'(cfg_data_i[0]);
        REG_DIAM:   diam_q   <= cfg_data_i;
        REG_BASE:   base_q   <= cfg_data_i;
        REG_LSLOPE: lslope_q <= cfg_data_i[23:0];
        REG_RSLOPE: rslope_q <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  logic     adv;
  logic     skid_valid_q, out_valid_q;
  csg_out_t skid_q, out_q, res;

  assign adv         = !skid_valid_q;
  assign in_ch.ready = adv;

  // input stage: clamp depth, fold geometry
  csg_word_t s0_d, s0_q;
  logic      v0_q;
  logic [31:0] dc;

  always_comb begin
    s0_d         = '0;
    dc           = (in_ch.flow_depth > diam_q) ? diam_q : in_ch.flow_depth;
    s0_d.shape   = shape_q;
    s0_d.clamped = (shape_q == SHAPE_PIPE) && (in_ch.flow_depth > diam_q);
    s0_d.neg     = {dc, 1'b0} > {1'b0, diam_q};
    s0_d.ax      = s0_d.neg ? 32'({dc, 1'b0} - {1'b0, diam_q})
                            : 32'({1'b0, diam_q} - {dc, 1'b0});
    s0_d.depth   = (shape_q == SHAPE_PIPE) ? dc : in_ch.flow_depth;
    s0_d.diam    = diam_q;
    s0_d.base    = base_q;
    s0_d.lslope  = lslope_q;
    s0_d.rslope  = rslope_q;
    s0_d.ssum    = 25'(lslope_q) + 25'(rslope_q);
  end

  // products feeding the root chain
  csg_root_t   s1_d, s1_q;
  logic        v1_q;
  logic [47:0] lsq, rsq;
  logic [48:0] lt, rt;

  always_comb begin
    s1_d         = '0;
    s1_d.w       = s0_q;
    s1_d.w.dss   = s0_q.depth * s0_q.ssum;
    s1_d.w.bd    = s0_q.base * s0_q.depth;
    s1_d.w.dsq   = s0_q.diam * s0_q.diam;
    lsq          = s0_q.lslope * s0_q.lslope;
    rsq          = s0_q.rslope * s0_q.rslope;
    lt           = 49'(lsq) + (49'd1 << 32);
    rt           = 49'(rsq) + (49'd1 << 32);
    s1_d.rad[0]  = s0_q.depth * 32'(s0_q.diam - s0_q.depth);
    s1_d.rad[1]  = {3'd0, lt, 12'd0};
    s1_d.rad[2]  = {3'd0, rt, 12'd0};
  end

  csg_root_t root_w [ROOT_STEPS+1];
  logic      root_v [ROOT_STEPS+1];
  assign root_w[0] = s1_q;
  assign root_v[0] = v1_q;

  for (genvar g = 0; g < ROOT_STEPS; g++) begin : g_root
    csg_root_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .step_i  (RSW'(g)),
      .valid_i (root_v[g]),
      .d_i     (root_w[g]),
      .valid_o (root_v[g+1]),
      .q_o     (root_w[g+1])
    );
  end

  // normalize the vector for the angle chain, trapezoid products
  csg_rot_t    s2_d, s2_q;
  logic        v2_q;
  csg_word_t   w2;
  logic [40:0] x, y, mag;
  logic [5:0]  pos, sh;

  always_comb begin
    w2       = root_w[ROOT_STEPS].w;
    w2.s     = root_w[ROOT_STEPS].root[0][31:0];
    w2.k     = 33'(root_w[ROOT_STEPS].root[1][31:0]) +
               33'(root_w[ROOT_STEPS].root[2][31:0]);
    w2.width = (w2.shape == SHAPE_TRAP) ? 48'(w2.base) + 48'(w2.dss >> 16)
                                        : 48'({w2.s, 1'b0});
    w2.prod_lo = w2.dss[31:0] * w2.depth;
    w2.prod_hi = w2.dss[56:32] * w2.depth;
    w2.dk      = w2.depth * w2.k;
    x   = 41'(w2.ax);
    y   = 41'({w2.s, 1'b0});
    mag = (x > y) ? x : y;
    pos = '0;
    for (int i = 0; i < 41; i++) begin
      if (mag[i]) pos = 6'(i);
    end
    sh      = 6'd40 - pos;
    s2_d.w  = w2;
    s2_d.cx = signed'(CW'(x) << sh);
    s2_d.cy = signed'(CW'(y) << sh);
    s2_d.z  = '0;
  end

  csg_rot_t rot_w [ANGLE_ITERATIONS+1];
  logic     rot_v [ANGLE_ITERATIONS+1];
  assign rot_w[0] = s2_q;
  assign rot_v[0] = v2_q;

  for (genvar g = 0; g < ANGLE_ITERATIONS; g++) begin : g_rot
    csg_rot_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .step_i  (AIW'(g)),
      .valid_i (rot_v[g]),
      .d_i     (rot_w[g]),
      .valid_o (rot_v[g+1]),
      .q_o     (rot_w[g+1])
    );
  end

  // half angle, trapezoid area and perimeter
  csg_word_t s3_d, s3_q;
  logic      v3_q;
  logic signed [ZW-1:0] z;
  logic [PW-1:0] zc;
  logic [89:0]   tsum;

  always_comb begin
    s3_d = rot_w[ANGLE_ITERATIONS].w;
    z    = rot_w[ANGLE_ITERATIONS].z;
    if (z[ZW-1]) begin
      zc = '0;
    end else if (ZW'(z) > ZW'(ZMAX)) begin
      zc = ZMAX;
    end else begin
      zc = PW'(z);
    end
    if (s3_d.s == '0) begin
      s3_d.phi = s3_d.neg ? PI_ANG : '0;
    end else begin
      s3_d.phi = s3_d.neg ? PI_ANG - zc : zc;
    end
    tsum        = {s3_d.prod_hi, 32'd0} + 90'(s3_d.prod_lo);
    s3_d.tarea  = 64'(s3_d.bd >> 16) + 64'(tsum >> 33);
    s3_d.tperim = 48'(s3_d.base) + 48'(s3_d.dk >> 22);
  end

  // pipe perimeter and area partial products
  csg_word_t   s4_d, s4_q;
  logic        v4_q;
  logic [63:0] pd;

  always_comb begin
    s4_d        = s3_q;
    pd          = s3_q.phi * s3_q.diam;
    s4_d.cperim = 48'(pd >> FRACTION_BITS);
    s4_d.pp_lo  = s3_q.dsq[31:0] * s3_q.phi;
    s4_d.pp_hi  = s3_q.dsq[63:32] * s3_q.phi;
    s4_d.axs    = s3_q.ax * s3_q.s;
  end

  // combine pipe area, pick the section
  csg_word_t   s5_d, s5_q;
  logic        v5_q;
  logic [95:0] psum;
  logic [63:0] t1, t2, carea;

  always_comb begin
    s5_d  = s4_q;
    psum  = {s4_q.pp_hi, 32'd0} + 96'(s4_q.pp_lo);
    t1    = 64'(psum >> (FRACTION_BITS + 18));
    t2    = s4_q.axs >> 17;
    if (s4_q.neg) begin
      carea = t1 + t2;
    end else begin
      carea = (t1 > t2) ? t1 - t2 : '0;
    end
    s5_d.area  = (s4_q.shape == SHAPE_TRAP) ? s4_q.tarea : carea;
    s5_d.perim = (s4_q.shape == SHAPE_TRAP) ? s4_q.tperim : s4_q.cperim;
  end

  // divider setup
  csg_div_t s6_d, s6_q;
  logic     v6_q;

  always_comb begin
    s6_d         = '0;
    s6_d.w       = s5_q;
    s6_d.w.pzero = (s5_q.perim == '0);
    s6_d.w.hrsat = s5_q.area >= {s5_q.perim, 16'd0};
    s6_d.rem     = {s5_q.area, 16'd0};
  end

  csg_div_t div_w [DIV_STEPS+1];
  logic     div_v [DIV_STEPS+1];
  assign div_w[0] = s6_q;
  assign div_v[0] = v6_q;

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    csg_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .step_i  (DSW'(g)),
      .valid_i (div_v[g]),
      .d_i     (div_w[g]),
      .valid_o (div_v[g+1]),
      .q_o     (div_w[g+1])
    );
  end

  // saturate and encode status
  csg_word_t wl;
  logic      sat;

  always_comb begin
    wl  = div_w[DIV_STEPS].w;
    sat = (!wl.pzero && wl.hrsat) || (wl.area > 64'(MAX48));
    res.flow_area        = (wl.area > 64'(MAX48)) ? MAX48 : wl.area[47:0];
    res.wetted_perimeter = wl.perim;
    res.surface_width    = wl.width;
    if (wl.pzero) begin
      res.hydraulic_radius = '0;
    end else if (wl.hrsat) begin
      res.hydraulic_radius = '1;
    end else begin
      res.hydraulic_radius = div_w[DIV_STEPS].quo;
    end
    if (sat) begin
      res.status = ST_SAT;
    end else if (wl.clamped) begin
      res.status = ST_CLAMP;
    end else begin
      res.status = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (adv) begin
      v0_q <= in_ch.valid;
      v1_q <= v0_q;
      v2_q <= root_v[ROOT_STEPS];
      v3_q <= rot_v[ANGLE_ITERATIONS];
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_q <= s0_d;
      s1_q <= s1_d;
      s2_q <= s2_d;
      s3_q <= s3_d;
      s4_q <= s4_d;
      s5_q <= s5_d;
      s6_q <= s6_d;
    end
  end

  // output register with skid
  logic out_take, last_v;
  assign out_take = out_valid_q && out_ch.ready;
  assign last_v   = div_v[DIV_STEPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) skid_valid_q <= 1'b0;
    end else if (last_v) begin
      if (!out_valid_q || out_take) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) out_q <= skid_q;
    end else if (last_v) begin
      if (!out_valid_q || out_take) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign out_ch.valid            = out_valid_q;
  assign out_ch.flow_area        = out_q.flow_area;
  assign out_ch.wetted_perimeter = out_q.wetted_perimeter;
  assign out_ch.surface_width    = out_q.surface_width;
  assign out_ch.hydraulic_radius = out_q.hydraulic_radius;
  assign out_ch.status           = out_q.status;
endmodule

// ===== src/csg_checker.sv =====
`timescale 1ns / 1ps
module csg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [47:0] out_area_i,
  input logic [47:0] out_perim_i,
  input logic [31:0] out_radius_i,
  input logic [1:0]  out_status_i
);
  import csg_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_area_i) &&
    $stable(out_radius_i))
    else $error("output beat changed while stalled");

  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> $past(out_valid_i && !out_ready_i))
    else $error("input stalled without output back-pressure");

  a_zero_perim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_perim_i == '0 |-> out_radius_i == '0)
    else $error("nonzero radius at zero perimeter");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_status_i == ST_OK || out_status_i == ST_CLAMP ||
    out_status_i == ST_SAT)
    else $error("undefined status code");
endmodule

bind channel_section_geometry csg_checker u_csg_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (in_ch.ready),
  .out_valid_i  (out_ch.valid),
  .out_ready_i  (out_ch.ready),
  .out_area_i   (out_ch.flow_area),
  .out_perim_i  (out_ch.wetted_perimeter),
  .out_radius_i (out_ch.hydraulic_radius),
  .out_status_i (out_ch.status)
);
